// File: src/pfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants of the postfix expression evaluator
// Character codes, status codes, operation codes and controller states.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_PLUS   = 8'd43;
   localparam logic [7:0] CH_MINUS  = 8'd45;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_SLASH  = 8'd47;
   localparam logic [7:0] CH_CARET  = 8'd94;
   localparam logic [7:0] CH_LPAREN = 8'd40;
   localparam logic [7:0] CH_RPAREN = 8'd41;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_DIVZ  = 3'd3,
      ST_ZNEG  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW, OP_DROP
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD_SECOND, S_RD_FIRST, S_EXEC, S_ITER,
      S_FINISH, S_WRITE, S_RD_TOP, S_TOP, S_OUT
   } state_type;

   typedef struct packed {
      logic       load;      // capture input beat
      logic       push_operand;
      logic       rd_second;
      logic       rd_first;
      logic       start_op;
      logic       step;
      logic       finish;
      logic       write_result;
      logic       pop_two;
      logic       take_top;
      logic       end_expr;
      logic       latch_valid;
      status_type latch_code;
   } cmd_type;

   typedef struct packed {
      logic       is_operand;
      logic       is_push_op;
      logic       full;
      logic       lt_two;
      logic       empty;
      logic       last;
      logic       iter_done;
      logic       needs_iter;
   } sts_type;

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_CARET) || (c == CH_LPAREN) ||
             (c == CH_RPAREN);
   endfunction

endpackage
`default_nettype wire

// File: src/pfe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_datapath: value stack, operand registers and shared arithmetic unit
// Stack memory with registered read, iterative divider and power unit.
// ----------------------------------------------------------------------------
module pfe_datapath
   import pfe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  char_code,
   input  wire logic        last_char,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic [31:0]      value,
   output logic [2:0]       status
);

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_data_ff;
   logic [7:0]  ch_ff;
   logic        last_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   status_type  err_ff, err_in;
   op_type      op_ff, op_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [31:0] acc_ff, acc_in, base_ff, base_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  it_ff, it_in;
   logic        neg_ff, neg_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  status_ff;

   logic [PTR_W-1:0] rd_addr, wr_addr;
   logic        wr_en;
   logic [31:0] wr_data;
   logic        latch_en;
   status_type  latch_code;
   logic [32:0] diff;
   logic [31:0] rem_sh;
   logic [31:0] mag_a, mag_b;

   always_comb begin
      rd_addr = cnt_ff[PTR_W-1:0] - PTR_W'(1);
      if (cmd.rd_second) rd_addr = cnt_ff[PTR_W-1:0] - PTR_W'(2);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[PTR_W-1:0];
      wr_data = 32'(ch_ff - CH_ZERO);
      if (cmd.push_operand) begin
         wr_en = 1'b1;
         wr_data = {{24{1'b0}}, ch_ff} - 32'(CH_ZERO);
      end else if (cmd.write_result) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[PTR_W-1:0] - PTR_W'(2);
         wr_data = res_ff;
      end
   end

   assign mag_a  = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign mag_b  = b_ff[31] ? (32'd0 - b_ff) : b_ff;
   assign rem_sh = {rem_ff[30:0], acc_ff[31]};
   assign diff   = {1'b0, rem_sh} - {1'b0, b_ff};

   always_comb begin
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      rem_in   = rem_ff;
      it_in    = it_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      value_in = value_ff;
      latch_en   = cmd.latch_valid;
      latch_code = cmd.latch_code;
      if (cmd.push_operand) cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.load) begin
         unique case (char_code)
            CH_PLUS:  op_in = OP_ADD;
            CH_MINUS: op_in = OP_SUB;
            CH_STAR:  op_in = OP_MUL;
            CH_SLASH: op_in = OP_DIV;
            CH_CARET: op_in = OP_POW;
            default:  op_in = OP_DROP;
         endcase
      end
      if (cmd.rd_second) b_in = rd_data_ff;
      if (cmd.rd_first)  a_in = rd_data_ff;
      if (cmd.start_op) begin
         it_in = 6'd0;
         unique case (op_ff)
            OP_ADD: res_in = a_ff + b_ff;
            OP_SUB: res_in = a_ff - b_ff;
            OP_MUL: res_in = a_ff * b_ff;
            OP_DIV: begin
               neg_in = a_ff[31] ^ b_ff[31];
               acc_in = mag_a;
               rem_in = 32'd0;
               b_in   = mag_b;
               if (b_ff == 32'd0) begin
                  res_in = 32'd0;
                  latch_en = 1'b1;
                  latch_code = ST_DIVZ;
               end
            end
            OP_POW: begin
               acc_in  = 32'd1;
               base_in = a_ff;
               if (b_ff[31]) begin
                  if (a_ff == 32'd1) res_in = 32'd1;
                  else if (a_ff == 32'hFFFF_FFFF) res_in = b_ff[0] ? a_ff : 32'd1;
                  else begin
                     res_in = 32'd0;
                     if (a_ff == 32'd0) begin
                        latch_en = 1'b1;
                        latch_code = ST_ZNEG;
                     end
                  end
               end
            end
            default: res_in = 32'd0;
         endcase
      end
      if (cmd.step) begin
         it_in = it_ff + 6'd1;
         if (op_ff == OP_DIV) begin
            if (!diff[32]) rem_in = diff[31:0];
            else rem_in = rem_sh;
            acc_in = {acc_ff[30:0], ~diff[32]};
         end else if (it_ff[0] == 1'b0) begin
            // even cycle: multiply into result when exponent bit set
            if (b_ff[0]) acc_in = acc_ff * base_ff;
         end else begin
            base_in = base_ff * base_ff;
            b_in    = {1'b0, b_ff[31:1]};
         end
      end
      if (cmd.finish) res_in = (op_ff == OP_DIV) ? (neg_ff ? 32'd0 - acc_ff : acc_ff) : acc_ff;
      if (cmd.pop_two) cnt_in = cnt_ff - CNT_W'(2) + CNT_W'(op_ff != OP_DROP);
      if (cmd.take_top) value_in = (cnt_ff == '0) ? 32'd0 : rd_data_ff;
      if (cmd.end_expr) cnt_in = '0;
   end

   always_comb begin
      err_in = err_ff;
      if (latch_en && err_ff == ST_OK) err_in = latch_code;
      if (cmd.end_expr) err_in = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         err_ff <= ST_OK;
      end else begin
         cnt_ff <= cnt_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff   <= char_code;
         last_ff <= last_char;
      end
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      rem_ff   <= rem_in;
      it_ff    <= it_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
      value_ff <= value_in;
      if (cmd.end_expr) status_ff <= 3'((err_ff == ST_OK && latch_en) ? latch_code : err_ff);
   end

   assign sts.is_operand = !is_operator(ch_ff);
   assign sts.is_push_op = (op_ff != OP_DROP);
   assign sts.full       = (cnt_ff >= CNT_W'(STACK_DEPTH));
   assign sts.lt_two     = (cnt_ff < CNT_W'(2));
   assign sts.empty      = (cnt_ff == '0);
   assign sts.last       = last_ff;
   assign sts.needs_iter = ((op_ff == OP_DIV) && (b_ff != 32'd0)) ||
                           ((op_ff == OP_POW) && !b_ff[31]);
   assign sts.iter_done  = (op_ff == OP_DIV) ? (it_ff == 6'd31) : (it_ff == 6'd61);

   assign value  = value_ff;
   assign status = status_ff;

endmodule
`default_nettype wire

// File: src/pfe_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_control: sequencer of the postfix evaluator
// Steps each character through stack reads, execution and write-back.
// ----------------------------------------------------------------------------
module pfe_control
   import pfe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.latch_code = ST_OK;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_operand) begin
               if (sts.full) begin
                  cmd.latch_valid = 1'b1;
                  cmd.latch_code  = ST_OVER;
               end else cmd.push_operand = 1'b1;
               state_in = sts.last ? S_RD_TOP : S_IDLE;
            end else if (sts.lt_two) begin
               cmd.latch_valid = 1'b1;
               cmd.latch_code  = ST_UNDER;
               state_in = sts.last ? S_RD_TOP : S_IDLE;
            end else begin
               state_in = S_RD_SECOND;
            end
         end
         S_RD_SECOND: begin
            cmd.rd_second = 1'b1;
            state_in = S_RD_FIRST;
         end
         S_RD_FIRST: begin
            cmd.rd_first = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.start_op = 1'b1;
            state_in = sts.needs_iter ? S_ITER : S_WRITE;
         end
         S_ITER: begin
            cmd.step = 1'b1;
            if (sts.iter_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_result = sts.is_push_op;
            cmd.pop_two = 1'b1;
            state_in = sts.last ? S_RD_TOP : S_IDLE;
         end
         S_RD_TOP: begin
            state_in = S_TOP;
         end
         S_TOP: begin
            cmd.take_top = 1'b1;
            cmd.end_expr = 1'b1;
            cmd.latch_valid = sts.empty;
            cmd.latch_code  = ST_UNDER;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: src/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: top level
// Evaluates a postfix expression, one character per beat, on a value stack.
//
// Channel  Ports                              Dir
// req      req_valid req_ready req_char_code req_last_char   in
// rsp      rsp_valid rsp_ready rsp_value rsp_status          out
//
// A new beat is taken only in the idle state, once the previous beat is done.
// Divide and power iterate the shared shift/multiply unit in the datapath.
// A last beat also reads the stack top and then waits for rsp_ready.
// Reset is synchronous and clears stack count and error code; no clearing pass.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
   import pfe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [2:0]       rsp_status
);

   cmd_type cmd;
   sts_type sts;
   logic [31:0] value;

   pfe_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   pfe_datapath u_datapath (
      .clock, .reset, .char_code(req_char_code), .last_char(req_last_char),
      .cmd, .sts, .value, .status(rsp_status)
   );

   assign rsp_value = signed'(value);

endmodule
`default_nettype wire

// File: src/pfe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_checker: port-level checks of the postfix evaluator
// Handshake and status range checks, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_value,
   input wire logic [2:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("rsp beat changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd4)
      else $error("rsp status out of range");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input taken while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_value, .rsp_status
);
`default_nettype wire

// File: tb/tb_postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator: self-checking testbench
// Drives postfix expressions one character per beat, predicts the stack top
// and status of every last beat, and checks each response beat in order.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
   import pfe_pkg::*;

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         status;
   } result_type;

   int errors = 0;

   task automatic report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   class rpn_scoreboard;
      logic [31:0] stack [STACK_DEPTH];
      int          depth;
      status_type  err;
      result_type  pending [$];

      function new();
         depth = 0;
         err   = ST_OK;
      endfunction

      function void flag(input status_type code);
         if (err == ST_OK) err = code;
      endfunction

      function logic [31:0] mag(input logic [31:0] v);
         return v[31] ? (32'd0 - v) : v;
      endfunction

      function bit is_op(input logic [7:0] c);
         return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                c == CH_CARET || c == CH_LPAREN || c == CH_RPAREN;
      endfunction

      function logic [31:0] power(input logic [31:0] b, input logic [31:0] e);
         logic [31:0] r;
         logic [31:0] x;
         r = 32'd1;
         x = b;
         if (e[31]) begin
            if (b == 32'd1) return 32'd1;
            if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
            if (b == 32'd0) flag(ST_ZNEG);
            return 32'd0;
         end
         for (int i = 0; i < 31; i++) begin
            if (e[i]) r = r * x;
            x = x * x;
         end
         return r;
      endfunction

      function void note_char(input logic [7:0] c, input logic last);
         logic [31:0] a;
         logic [31:0] b;
         logic [31:0] r;
         result_type  res;
         if (!is_op(c)) begin
            if (depth >= STACK_DEPTH) flag(ST_OVER);
            else stack[depth++] = {24'd0, c} - 32'd48;
         end else if (depth < 2) begin
            flag(ST_UNDER);
         end else begin
            b = stack[depth - 1];
            a = stack[depth - 2];
            depth -= 2;
            r = 32'd0;
            case (c)
               CH_PLUS:  r = a + b;
               CH_MINUS: r = a - b;
               CH_STAR:  r = a * b;
               CH_SLASH: begin
                  if (b == 0) flag(ST_DIVZ);
                  else begin
                     r = mag(a) / mag(b);
                     if (a[31] ^ b[31]) r = 32'd0 - r;
                  end
               end
               CH_CARET: r = power(a, b);
               default: ;
            endcase
            if (c != CH_LPAREN && c != CH_RPAREN) stack[depth++] = r;
         end
         if (last) begin
            if (depth == 0) begin
               flag(ST_UNDER);
               res.value = 0;
            end else res.value = stack[depth - 1];
            res.status = err;
            pending.push_back(res);
            depth = 0;
            err   = ST_OK;
         end
      endfunction

      task check(input logic signed [31:0] v, input logic [2:0] s);
         result_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected rsp beat value=%0d status=%0d", v, s));
            return;
         end
         e = pending.pop_front();
         if (v !== e.value)
            report($sformatf("value %0d, expected %0d", v, e.value));
         if (s !== e.status)
            report($sformatf("status %0d, expected %0d", s, e.status));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [7:0] req_char_code = 0;
   logic req_last_char = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_value;
   logic [2:0] rsp_status;
   bit quiet = 0;
   longint cycles = 0;
   rpn_scoreboard sb = new();

   postfix_expression_evaluator dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2_000_000) begin
         $display("** postfix_expression_evaluator: FAILED **");
         $finish;
      end
   end

   // response side: random stall bursts, checks on every accepted beat
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 7);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check(rsp_value, rsp_status);
      end
   end

   task automatic send(input logic [7:0] c, input logic last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid     <= 1;
      req_char_code <= c;
      req_last_char <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_char(c, last);
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] rand_operand();
      logic [7:0] c;
      if ($urandom_range(0, 3) != 0) return 8'(48 + $urandom_range(0, 9));
      do c = 8'($urandom_range(0, 255)); while (sb.is_op(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_operator();
      case ($urandom_range(0, 7))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_STAR;
         3: return CH_SLASH;
         4: return CH_CARET;
         5: return CH_LPAREN;
         6: return CH_RPAREN;
         default: return CH_MINUS;
      endcase
   endfunction

   task automatic send_expr(output int sent);
      int need;
      int len;
      int k;
      len = $urandom_range(1, 12);
      k = 0;
      need = 0;
      for (int i = 0; i < len; i++) begin
         if (need >= 2 && $urandom_range(0, 1)) begin
            send(rand_operator(), i == len - 1);
            need--;
         end else begin
            send(rand_operand(), i == len - 1);
            need++;
         end
      end
      sent = len;
   endtask

   initial begin
      int count;
      int sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_str("34+");
      send_str("95-");
      send_str("78*");
      send_str("~3/");
      send_str("0\x01-/");
      send_str("90/");
      send_str("23^");
      send_str("20-1-^");
      send_str("00^");
      send_str("00/");
      send_str("/");
      send_str("12()");
      send_str("\xff\x00");
      send_str("3");
      for (int i = 0; i < 66; i++) send(8'd57, i == 65);
      send_str("~~*~*~*9*~*");
      send_str("\x0009^/");
      count = 0;
      while (count < 1900) begin
         if (count > 1700) quiet = 1;
         if ($urandom_range(0, 9) == 0) begin
            send(rand_operator(), 1'($urandom_range(0, 1)));
            count++;
         end else begin
            send_expr(sent);
            count += sent;
         end
      end
      send(8'd49, 1);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("** postfix_expression_evaluator: PASSED **");
      else $display("** postfix_expression_evaluator: FAILED **");
      $finish;
   end
endmodule
